@@ rtl/upd_pkg.sv @@
// Package for the URL percent decoder: character codes, escape phase type,
// beat structs and the digit decode function. No dependencies.
`default_nettype none

package upd_pkg;

  // Character codes
  localparam logic [7:0] CH_PLUS    = 8'h2B;
  localparam logic [7:0] CH_PERCENT = 8'h25;
  localparam logic [7:0] CH_SPACE   = 8'h20;
  localparam logic [7:0] CH_ZERO    = 8'h30;
  localparam logic [7:0] CH_NINE    = 8'h39;
  localparam logic [7:0] CH_LOWER_A = 8'h61;
  localparam logic [7:0] CH_LOWER_Z = 8'h7A;
  localparam logic [7:0] CH_UPPER_A = 8'h41;
  localparam logic [7:0] CH_UPPER_Z = 8'h5A;
  localparam logic [5:0] LETTER_BASE = 6'd10;

  // Field widths and register reset
  localparam int unsigned BYTE_W  = 8;
  localparam int unsigned COUNT_W = 13;
  localparam int unsigned DIGIT_W = 6;
  localparam logic [COUNT_W-1:0] CAPACITY_RESET = 13'd128;

  // Escape sequence progress
  typedef enum logic [1:0] {
    PH_PLAIN  = 2'd0,
    PH_FIRST  = 2'd1,
    PH_SECOND = 2'd2
  } phase_t;

  // One input beat
  typedef struct packed {
    logic [BYTE_W-1:0] in_byte;
    logic              is_final;
  } in_beat_t;

  // One result beat
  typedef struct packed {
    logic               out_valid;
    logic [BYTE_W-1:0]  out_byte;
    logic [COUNT_W-1:0] decoded_count;
    logic               string_done;
    logic               truncated;
  } out_beat_t;

  // Decoded escape digit
  typedef struct packed {
    logic               ok;
    logic [DIGIT_W-1:0] val;
  } digit_t;

  // Map '0'-'9' to 0-9 and letters of either case to 10-35
  function automatic digit_t digit_value(input logic [BYTE_W-1:0] c);
    digit_t d;
    logic [BYTE_W-1:0] off;
    d   = '0;
    off = '0;
    if (c >= CH_ZERO && c <= CH_NINE) begin
      off   = c - CH_ZERO;
      d.ok  = 1'b1;
      d.val = off[DIGIT_W-1:0];
    end else if (c >= CH_LOWER_A && c <= CH_LOWER_Z) begin
      off   = c - CH_LOWER_A;
      d.ok  = 1'b1;
      d.val = off[DIGIT_W-1:0] + LETTER_BASE;
    end else if (c >= CH_UPPER_A && c <= CH_UPPER_Z) begin
      off   = c - CH_UPPER_A;
      d.ok  = 1'b1;
      d.val = off[DIGIT_W-1:0] + LETTER_BASE;
    end
    return d;
  endfunction

endpackage

`default_nettype wire

@@ rtl/upd_if.sv @@
// Valid/ready channel interfaces for the URL percent decoder.
// Depends on upd_pkg for field widths.
`default_nettype none

interface upd_in_if;
  logic                          valid;
  logic                          ready;
  logic [upd_pkg::BYTE_W-1:0]    in_byte;
  logic                          is_final;

  modport source (output valid, output in_byte, output is_final, input ready);
  modport sink   (input valid, input in_byte, input is_final, output ready);
endinterface

interface upd_out_if;
  logic                          valid;
  logic                          ready;
  logic                          out_valid;
  logic [upd_pkg::BYTE_W-1:0]    out_byte;
  logic [upd_pkg::COUNT_W-1:0]   decoded_count;
  logic                          string_done;
  logic                          truncated;

  modport source (output valid, output out_valid, output out_byte, output decoded_count,
                  output string_done, output truncated, input ready);
  modport sink   (input valid, input out_valid, input out_byte, input decoded_count,
                  input string_done, input truncated, output ready);
endinterface

`default_nettype wire

@@ rtl/upd_in_stage.sv @@
// Input register of the URL percent decoder: captures one beat from the
// input channel. Depends on upd_pkg and upd_in_if.
`default_nettype none

module upd_in_stage (
  input  wire logic              clk,
  input  wire logic              rst,
  upd_in_if.sink                 in_ch,
  input  wire logic              advance,
  output upd_pkg::in_beat_t      beat,
  output logic                   beat_valid
);

  // Take a new beat when empty or when the held one moves on
  assign in_ch.ready = !beat_valid || advance;

  // Track occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      beat_valid <= 1'b0;
    end else if (in_ch.ready) begin
      beat_valid <= in_ch.valid;
    end
  end

  // Hold the payload
  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      beat.in_byte  <= in_ch.in_byte;
      beat.is_final <= in_ch.is_final;
    end
  end

endmodule

`default_nettype wire

@@ rtl/upd_decode.sv @@
// Decode stage of the URL percent decoder: escape state, output count and
// the result register. Depends on upd_pkg and upd_out_if.
`default_nettype none

module upd_decode (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic [upd_pkg::COUNT_W-1:0] capacity,
  input  wire upd_pkg::in_beat_t           beat,
  input  wire logic                        beat_valid,
  output logic                             advance,
  upd_out_if.source                        out_ch
);

  upd_pkg::phase_t                 phase, phase_next;
  logic [upd_pkg::DIGIT_W-1:0]     held, held_next;
  logic                            held_ok, held_ok_next;
  logic [upd_pkg::COUNT_W-1:0]     count, count_next;
  logic [upd_pkg::COUNT_W-1:0]     count_upd;
  logic                            emit;
  logic [upd_pkg::BYTE_W-1:0]      ob;
  upd_pkg::digit_t                 dig;
  upd_pkg::out_beat_t              res, res_next;
  logic                            res_valid;

  // Move the held beat on when the result register is free or draining
  assign advance = beat_valid && (!res_valid || out_ch.ready);
  assign dig     = upd_pkg::digit_value(beat.in_byte);

  // Work out emission and the escape state for the held byte
  always_comb begin
    phase_next   = phase;
    held_next    = held;
    held_ok_next = held_ok;
    emit         = 1'b0;
    ob           = '0;
    if (count < capacity) begin
      case (phase)
        upd_pkg::PH_FIRST: begin
          if (beat.is_final) begin
            phase_next = upd_pkg::PH_PLAIN;
            emit       = (beat.in_byte != upd_pkg::CH_PERCENT);
            ob         = (beat.in_byte == upd_pkg::CH_PLUS) ? upd_pkg::CH_SPACE
                                                            : beat.in_byte;
          end else begin
            held_ok_next = dig.ok;
            held_next    = dig.val;
            phase_next   = upd_pkg::PH_SECOND;
          end
        end
        upd_pkg::PH_SECOND: begin
          emit         = dig.ok && held_ok;
          ob           = {held[3:0], 4'b0000} | {2'b00, dig.val};
          phase_next   = upd_pkg::PH_PLAIN;
          held_next    = '0;
          held_ok_next = 1'b0;
        end
        default: begin
          phase_next = upd_pkg::PH_PLAIN;
          if (beat.in_byte == upd_pkg::CH_PERCENT) begin
            if (!beat.is_final) begin
              phase_next = upd_pkg::PH_FIRST;
            end
          end else begin
            emit = 1'b1;
            ob   = (beat.in_byte == upd_pkg::CH_PLUS) ? upd_pkg::CH_SPACE : beat.in_byte;
          end
        end
      endcase
    end
    count_upd  = count + {{(upd_pkg::COUNT_W-1){1'b0}}, emit};
    count_next = count_upd;
    // Drop all string state after the final byte
    if (beat.is_final) begin
      phase_next   = upd_pkg::PH_PLAIN;
      held_next    = '0;
      held_ok_next = 1'b0;
      count_next   = '0;
    end
    res_next.out_valid     = emit;
    res_next.out_byte      = emit ? ob : '0;
    res_next.decoded_count = count_upd;
    res_next.string_done   = beat.is_final;
    res_next.truncated     = (count_upd >= capacity);
  end

  // Advance string state
  always_ff @(posedge clk) begin
    if (rst) begin
      phase   <= upd_pkg::PH_PLAIN;
      held    <= '0;
      held_ok <= 1'b0;
      count   <= '0;
    end else if (advance) begin
      phase   <= phase_next;
      held    <= held_next;
      held_ok <= held_ok_next;
      count   <= count_next;
    end
  end

  // Result register occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (advance) begin
      res_valid <= 1'b1;
    end else if (out_ch.ready) begin
      res_valid <= 1'b0;
    end
  end

  // Result payload
  always_ff @(posedge clk) begin
    if (advance) begin
      res <= res_next;
    end
  end

  assign out_ch.valid         = res_valid;
  assign out_ch.out_valid     = res.out_valid;
  assign out_ch.out_byte      = res.out_byte;
  assign out_ch.decoded_count = res.decoded_count;
  assign out_ch.string_done   = res.string_done;
  assign out_ch.truncated     = res.truncated;

  // A final byte leaves the block in plain mode with a cleared count
  a_final_clears: assert property (@(posedge clk) disable iff (rst)
    advance && beat.is_final |=> phase == upd_pkg::PH_PLAIN && count == '0 && !held_ok)
    else $error("string state not cleared after final byte");

  // The count moves by the emitted bit within a string
  a_count_step: assert property (@(posedge clk) disable iff (rst)
    advance && !beat.is_final |=> count == $past(count) + {{(upd_pkg::COUNT_W-1){1'b0}},
                                                          $past(emit)})
    else $error("count step does not match emission");

  // An emitted byte always carries a nonzero count
  a_emit_count: assert property (@(posedge clk) disable iff (rst)
    out_ch.valid && out_ch.out_valid |-> out_ch.decoded_count != '0)
    else $error("emitted byte with zero count");

  // A stalled result is not overwritten
  a_no_overrun: assert property (@(posedge clk) disable iff (rst)
    res_valid && !out_ch.ready |-> !advance)
    else $error("result register overwritten while stalled");

endmodule

`default_nettype wire

@@ rtl/url_percent_decoder_top.sv @@
// Top level of the URL percent decoder: capacity register, input stage
// and decode stage. Depends on upd_pkg, upd_if, upd_in_stage, upd_decode.
//
//   channel   dir  payload                                           beat
//   in_ch     in   in_byte[7:0], is_final                             valid & ready
//   out_ch    out  out_valid, out_byte[7:0], decoded_count[12:0],
//                  string_done, truncated                             valid & ready
//   cfg       in   cfg_wr_data[12:0] (output_capacity)                cfg_wr_en
//
// One beat per cycle in and out while out_ch is ready; a result passes through
// the input register, then the result register, before it is presented.
// The escape state and count update in the decode stage when the result register loads.
// Reset is synchronous and active high; capacity resets to 128.
// A stall on out_ch fills the result register, then the input register,
// after which in_ch.ready drops.
`default_nettype none

module url_percent_decoder_top (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        cfg_wr_en,
  input  wire logic [upd_pkg::COUNT_W-1:0] cfg_wr_data,
  upd_in_if.sink                           in_ch,
  upd_out_if.source                        out_ch
);

  logic [upd_pkg::COUNT_W-1:0] capacity;
  upd_pkg::in_beat_t           beat;
  logic                        beat_valid;
  logic                        advance;

  // Capacity register
  always_ff @(posedge clk) begin
    if (rst) begin
      capacity <= upd_pkg::CAPACITY_RESET;
    end else if (cfg_wr_en) begin
      capacity <= cfg_wr_data;
    end
  end

  upd_in_stage u_in (
    .clk        (clk),
    .rst        (rst),
    .in_ch      (in_ch),
    .advance    (advance),
    .beat       (beat),
    .beat_valid (beat_valid)
  );

  upd_decode u_dec (
    .clk        (clk),
    .rst        (rst),
    .capacity   (capacity),
    .beat       (beat),
    .beat_valid (beat_valid),
    .advance    (advance),
    .out_ch     (out_ch)
  );

endmodule

`default_nettype wire
